FILE: design/bb3_pkg.sv
// Package for the 3x3 box blur: pixel and window types, register indexes,
// and the divide-by-nine helper used by the output stage.
// No dependencies.
`default_nettype none

package bb3_pkg;

  // Row position in the frame; it counts up to one past the tallest frame.
  localparam int unsigned ROW_W = 14;

  // Widths of the configuration registers and of the write data.
  localparam int unsigned FW_W   = 11;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned CFG_DW = 13;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // The sum of nine 8-bit samples fits in 12 bits. Multiplying by
  // ceil(2^16 / 9) and dropping 16 bits gives the exact quotient there.
  localparam int unsigned   SUM_W  = 12;
  localparam int unsigned   PROD_W = 25;
  localparam logic [12:0]   RECIP9 = 13'd7282;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Index order is [row][column]; row 0 is the oldest line and column 2
  // the newest pixel.
  typedef pixel_t [2:0][2:0] win_t;

  typedef struct packed {
    win_t win;
    logic border;
    logic frame_end;
  } s1_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(RECIP9);
    return prod[23:16];
  endfunction

endpackage

`default_nettype wire

FILE: design/bb3_ram.sv
// Generic simple dual-port RAM with one write port and one registered
// read port (read-first on an address collision). No dependencies.
`default_nettype none

module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/bb3_out_stage.sv
// Output stage of the box blur: averages the window or passes the center
// pixel through, and holds the result until the receiver takes it.
// Depends on bb3_pkg.
`default_nettype none

module bb3_out_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s1_valid_i,
  input  wire bb3_pkg::s1_t s1_i,
  output logic              load_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic              frame_end_o
);

  logic            valid_q, valid_d;
  bb3_pkg::pixel_t pix_q, pix_d;
  logic            fe_q;
  logic            load;

  assign load_ready_o = !valid_q || !out_stall_i;
  assign load         = s1_valid_i && load_ready_o;

  always_comb begin
    logic [bb3_pkg::SUM_W-1:0] sum_r;
    logic [bb3_pkg::SUM_W-1:0] sum_g;
    logic [bb3_pkg::SUM_W-1:0] sum_b;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum_r = sum_r + bb3_pkg::SUM_W'(s1_i.win[i][j].red);
        sum_g = sum_g + bb3_pkg::SUM_W'(s1_i.win[i][j].green);
        sum_b = sum_b + bb3_pkg::SUM_W'(s1_i.win[i][j].blue);
      end
    end
    // The pixel being finished sits in the middle row, middle column.
    if (s1_i.border) begin
      pix_d = s1_i.win[1][1];
    end else begin
      pix_d.red   = bb3_pkg::div9(sum_r);
      pix_d.green = bb3_pkg::div9(sum_g);
      pix_d.blue  = bb3_pkg::div9(sum_b);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
      fe_q  <= s1_i.frame_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_red_o   = pix_q.red;
  assign out_green_o = pix_q.green;
  assign out_blue_o  = pix_q.blue;
  assign frame_end_o = fe_q;

endmodule

`default_nettype wire

FILE: design/box_blur_3x3_rgb.sv
// Top level of the 3x3 box blur over RGB888 raster frames.
// Depends on bb3_pkg, bb3_ram (two line stores) and bb3_out_stage.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+------------------------------------
//   input   | in_valid_i / in_stall_o  | cmd_i, in_red_i, in_green_i, in_blue_i
//   output  | out_valid_o/ out_stall_i | out_red_o, out_green_o, out_blue_o,
//           |                          | frame_end_o
//   config  | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One request is taken per clock while in_stall_o is low. A result that a
// request releases passes through the window and position register, then
// the averaging stage with its output register. Reads from the line stores
// are registered and addressed one position ahead, so they do not lengthen that path.
// Reset clears position, window and handshake state; line stores need none.
// A stalled output holds one result and one more in the window stage.
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire bb3_pkg::cfg_idx_e           cfg_index_i,
  input  wire logic [bb3_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        cmd_i,
  input  wire logic [7:0]                  in_red_i,
  input  wire logic [7:0]                  in_green_i,
  input  wire logic [7:0]                  in_blue_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic                             frame_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW = bb3_pkg::ROW_W;

  logic [bb3_pkg::FW_W-1:0] fw_q;
  logic [bb3_pkg::FH_W-1:0] fh_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] pend_q, pend_d;

  bb3_pkg::win_t   win_q, win_d;
  logic            border_q, border_d;
  logic            fe_q, fe_d;
  logic            s1_valid_q, s1_valid_d;
  bb3_pkg::s1_t    s1;

  logic            byp_q;
  bb3_pkg::pixel_t byp_up_q, byp_lo_q;
  bb3_pkg::pixel_t tail_q;

  logic [23:0]     up_rdata, lo_rdata;
  bb3_pkg::pixel_t top, mid, pix;

  logic [WW-1:0]             w;
  logic [bb3_pkg::FH_W-1:0]  hm1;
  logic [CW-1:0]             c;
  logic                      accept;
  logic                      emit;
  logic                      load_ready;

  // Effective frame size after clamping.
  always_comb begin
    logic [31:0] fw32;
    fw32 = 32'(fw_q);
    if (fw32 < 32'd3) begin
      fw32 = 32'd3;
    end else if (fw32 > MAX_WIDTH) begin
      fw32 = MAX_WIDTH;
    end
    w = fw32[WW-1:0];
    if (fh_q < bb3_pkg::FH_W'(3)) begin
      hm1 = bb3_pkg::FH_W'(2);
    end else begin
      hm1 = fh_q - bb3_pkg::FH_W'(1);
    end
  end

  assign c = (WW'(col_q) >= w) ? '0 : col_q;

  // A new request may enter unless the window stage holds a result that
  // cannot move on this cycle.
  assign in_stall_o = s1_valid_q && !load_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = pend_q >= (w + WW'(1));

  assign pix = cmd_i ? '0 : {in_red_i, in_green_i, in_blue_i};
  assign top = byp_q ? byp_up_q : bb3_pkg::pixel_t'(up_rdata);
  assign mid = byp_q ? byp_lo_q : bb3_pkg::pixel_t'(lo_rdata);

  always_comb begin
    logic [RW-1:0] qr;
    logic [CW-1:0] qc;
    logic          last;
    col_d      = col_q;
    row_d      = row_q;
    pend_d     = pend_q;
    win_d      = win_q;
    border_d   = border_q;
    fe_d       = fe_q;
    s1_valid_d = s1_valid_q && !load_ready;

    if (c == '0) begin
      qr = row_q - RW'(2);
      qc = CW'(w - WW'(1));
    end else begin
      qr = row_q - RW'(1);
      qc = c - CW'(1);
    end
    last = (qr == RW'(hm1)) && (WW'(qc) == w - WW'(1));

    if (cfg_we_i) begin
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else if (accept) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[0][2] = top;
      win_d[1][2] = mid;
      win_d[2][2] = pix;

      if (!emit) begin
        pend_d = pend_q + WW'(1);
      end
      if (WW'(c) + WW'(1) >= w) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = c + CW'(1);
      end

      if (emit) begin
        s1_valid_d = 1'b1;
        border_d   = (qr == '0) || (qr == RW'(hm1)) || (qc == '0)
                     || (WW'(qc) == w - WW'(1));
        fe_d       = last;
        if (last) begin
          col_d  = '0;
          row_d  = '0;
          pend_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= bb3_pkg::FW_RESET;
      fh_q <= bb3_pkg::FH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bb3_pkg::CFG_WIDTH:  fw_q <= cfg_data_i[bb3_pkg::FW_W-1:0];
        bb3_pkg::CFG_HEIGHT: fh_q <= cfg_data_i[bb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      win_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      pend_q     <= pend_d;
      win_q      <= win_d;
      s1_valid_q <= s1_valid_d;
      // At a frame restart the next read address equals this write address,
      // so the stores' old contents must be overridden for one cycle.
      byp_q      <= accept && (col_d == c);
    end
  end

  always_ff @(posedge clk_i) begin
    border_q <= border_d;
    fe_q     <= fe_d;
    if (accept) begin
      byp_up_q <= mid;
      byp_lo_q <= pix;
      if (WW'(c) == w - WW'(1)) begin
        tail_q <= mid;
      end
    end
  end

  // The last entry of the upper store is kept in a register because the
  // first-column result needs it alongside the normal column read.
  always_comb begin
    s1.win       = win_q;
    s1.border    = border_q;
    s1.frame_end = fe_q;
    if (c == '0 && !fe_q) begin
      s1.win = win_q;
    end
  end

  bb3_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (c),
    .wdata_i (mid),
    .raddr_i (col_d),
    .rdata_o (up_rdata)
  );

  bb3_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (c),
    .wdata_i (pix),
    .raddr_i (col_d),
    .rdata_o (lo_rdata)
  );

  bb3_pkg::s1_t s1_out;

  // For a first-column result the center pixel comes from the end of the
  // row two above, held in the tail register, not from the window.
  logic          s1_first_q;
  bb3_pkg::pixel_t s1_tail_q;

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_first_q <= (c == '0);
      s1_tail_q  <= tail_q;
    end
  end

  always_comb begin
    s1_out = s1;
    if (s1_first_q) begin
      s1_out.win[1][1] = s1_tail_q;
    end
  end

  bb3_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_i         (s1_out),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for box_blur_3x3_rgb: it drives raster frames and drain requests
// and predicts every blurred or passed-through pixel and its frame_end flag.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX    = 1024;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned TAIL_CYCLES = 5;
  localparam int unsigned RAND_ITEMS  = 780;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Blue values for the first directed frame; red is full and green empty.
  localparam logic [71:0] EDGE_BLUES = {8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01,
                                        8'hFE, 8'hAA, 8'h55, 8'h12};

  typedef enum int unsigned {
    SHAPE_CLEAN,
    SHAPE_NOISE,
    SHAPE_CUT,
    SHAPE_LONG
  } frame_shape_e;

  typedef struct packed {
    logic            cmd;
    bb3_pkg::pixel_t pix;
  } blur_req_t;

  typedef struct packed {
    bb3_pkg::pixel_t pix;
    logic            fe;
  } blur_res_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  bb3_pkg::cfg_idx_e          cfg_index_i = bb3_pkg::CFG_WIDTH;
  logic [bb3_pkg::CFG_DW-1:0] cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       cmd_i       = CMD_PIXEL;
  logic [7:0]                 in_red_i    = '0;
  logic [7:0]                 in_green_i  = '0;
  logic [7:0]                 in_blue_i   = '0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [7:0]                 out_red_o;
  logic [7:0]                 out_green_o;
  logic [7:0]                 out_blue_o;
  logic                       frame_end_o;

  blur_req_t   pixel_req_q[$];
  blur_res_t   blur_expect_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_delay = 0;
  int unsigned hold_left = 0;

  // Predictor state: programmed size, frame position and the pixel history.
  logic [bb3_pkg::FW_W-1:0] width_reg  = bb3_pkg::FW_RESET;
  logic [bb3_pkg::FH_W-1:0] height_reg = bb3_pkg::FH_RESET;
  int unsigned              col_pos = 0;
  int unsigned              row_pos = 0;
  int unsigned              pend_cnt = 0;
  bb3_pkg::pixel_t          upper_line [LINE_MAX] = '{default: '0};
  bb3_pkg::pixel_t          lower_line [LINE_MAX] = '{default: '0};
  bb3_pkg::pixel_t          wnd [3][3] = '{default: '0};

  box_blur_3x3_rgb #(
    .MAX_WIDTH(LINE_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .frame_end_o(frame_end_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned eff_width(input logic [bb3_pkg::FW_W-1:0] v);
    if (v < 3) return 3;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [bb3_pkg::FH_W-1:0] v);
    return (v < 3) ? 3 : v;
  endfunction

  function automatic void frame_restart();
    col_pos  = 0;
    row_pos  = 0;
    pend_cnt = 0;
  endfunction

  // Takes one request and returns 1 when it releases a result.
  function automatic bit blur_predict(input logic cmd, input bb3_pkg::pixel_t src,
                                      output blur_res_t res);
    int unsigned w, h, c, r, qr, qc, i, j, sr, sg, sb;
    bb3_pkg::pixel_t pix, top, mid, tail, center;
    bit emit, border;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    c = (col_pos >= w) ? 0 : col_pos;
    r = row_pos;
    res = '0;
    pix = (cmd == CMD_DRAIN) ? '0 : src;
    top  = upper_line[c];
    mid  = lower_line[c];
    tail = upper_line[w-1];
    upper_line[c] = mid;
    lower_line[c] = pix;
    for (i = 0; i < 3; i++) begin
      wnd[i][0] = wnd[i][1];
      wnd[i][1] = wnd[i][2];
    end
    wnd[0][2] = top;
    wnd[1][2] = mid;
    wnd[2][2] = pix;
    emit = (pend_cnt >= w + 1);
    if (!emit) pend_cnt++;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (!emit) return 1'b0;
    // At column zero the pixel released is the last one of the row two lines up.
    if (c == 0) begin
      qr = r - 2;
      qc = w - 1;
      center = tail;
    end else begin
      qr = r - 1;
      qc = c - 1;
      center = wnd[1][1];
    end
    border = (qr == 0) || (qr == h - 1) || (qc == 0) || (qc == w - 1);
    if (border) begin
      res.pix = center;
    end else begin
      sr = 0;
      sg = 0;
      sb = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          sr += wnd[i][j].red;
          sg += wnd[i][j].green;
          sb += wnd[i][j].blue;
        end
      end
      res.pix = {8'(sr / 9), 8'(sg / 9), 8'(sb / 9)};
    end
    res.fe = (qr == h - 1) && (qc == w - 1);
    if (res.fe) frame_restart();
    return 1'b1;
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic bb3_pkg::pixel_t rand_pixel();
    logic [7:0] ch [3];
    int unsigned i;
    for (i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0:       ch[i] = 8'h00;
        1:       ch[i] = 8'hFF;
        default: ch[i] = 8'($urandom);
      endcase
    end
    return {ch[0], ch[1], ch[2]};
  endfunction

  task automatic push_req(input logic cmd, input bb3_pkg::pixel_t pix);
    blur_req_t rq;
    rq.cmd = cmd;
    rq.pix = pix;
    pixel_req_q.push_back(rq);
  endtask

  // Queues one frame of w x h pixels and its w+1 drain requests, or a broken variant.
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input frame_shape_e shape, output int unsigned n);
    int unsigned total, k;
    logic cmd;
    total = h * w + w + 1;
    case (shape)
      SHAPE_CUT:  n = $urandom_range(total - 1, 1);
      SHAPE_LONG: n = total + $urandom_range(w, 1);
      default:    n = total;
    endcase
    for (k = 0; k < n; k++) begin
      if (shape == SHAPE_NOISE) cmd = ($urandom_range(4) == 0) ? CMD_DRAIN : CMD_PIXEL;
      else cmd = (k >= h * w) ? CMD_DRAIN : CMD_PIXEL;
      push_req(cmd, rand_pixel());
    end
  endtask

  task automatic set_reg(input bb3_pkg::cfg_idx_e idx,
                         input logic [bb3_pkg::CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_frame(input logic [bb3_pkg::CFG_DW-1:0] wdat,
                               input logic [bb3_pkg::CFG_DW-1:0] hdat);
    set_reg(bb3_pkg::CFG_WIDTH, wdat);
    set_reg(bb3_pkg::CFG_HEIGHT, hdat);
    @(negedge clk_i);
  endtask

  // Waits until every request is taken and every result is back, then lets
  // a request that releases nothing work its way through the pipeline.
  task automatic drain_wait();
    while (pixel_req_q.size() != 0 || in_valid_i || blur_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_req
    blur_req_t nxt;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_req_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= nxt.cmd;
        in_red_i   <= nxt.pix.red;
        in_green_i <= nxt.pix.green;
        in_blue_i  <= nxt.pix.blue;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : drive_stall
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (hold_delay != 0) begin
        hold_delay--;
        if (hold_delay == 0) hold_left = HOLD_CYCLES;
      end
      out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : observe
    blur_res_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (blur_expect_q.size() == 0) begin
          $display("%0t: expected no result, actual %h%h%h frame_end %b", $time,
                   out_red_o, out_green_o, out_blue_o, frame_end_o);
          mismatch_cnt++;
        end else begin
          want = blur_expect_q.pop_front();
          check_field("out_red", want.pix.red, out_red_o);
          check_field("out_green", want.pix.green, out_green_o);
          check_field("out_blue", want.pix.blue, out_blue_o);
          check_field("frame_end", want.fe, frame_end_o);
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == bb3_pkg::CFG_WIDTH) width_reg = cfg_data_i[bb3_pkg::FW_W-1:0];
        else height_reg = cfg_data_i[bb3_pkg::FH_W-1:0];
        frame_restart();
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (blur_predict(cmd_i, {in_red_i, in_green_i, in_blue_i}, want))
          blur_expect_q.push_back(want);
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned k, wv, hv, nfr, f, n, rand_items, pick;
    logic [bb3_pkg::CFG_DW-1:0] wdat, hdat;
    frame_shape_e shape;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 66;

    // Smallest frame: one interior pixel that averages the whole frame.
    program_frame(13'd3, 13'd3);
    for (k = 0; k < 9; k++) begin
      push_req(CMD_PIXEL, {8'hFF, 8'h00, EDGE_BLUES[8*k +: 8]});
    end
    for (k = 0; k < 4; k++) push_req(CMD_DRAIN, 24'hFFFFFF);
    drain_wait();

    // Width and height below the minimum; a drain lands on the interior pixel
    // and a pixel turns up among the drains.
    program_frame(13'h1800, 13'd1);
    for (k = 0; k < 13; k++) begin
      if (k == 4) push_req(CMD_DRAIN, 24'hFFFFFF);
      else if (k >= 9 && k != 11) push_req(CMD_DRAIN, rand_pixel());
      else push_req(CMD_PIXEL, rand_pixel());
    end
    drain_wait();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 66;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(19))
        0, 1:    wv = $urandom_range(2);
        2:       wv = $urandom_range(24, 13);
        default: wv = $urandom_range(12, 3);
      endcase
      hv = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
      wdat = {2'($urandom), 11'(wv)};
      hdat = 13'(hv);
      program_frame(wdat, hdat);
      nfr = $urandom_range(3, 1);
      for (f = 0; f < nfr; f++) begin
        pick = $urandom_range(99);
        if (pick < 75) shape = SHAPE_CLEAN;
        else if (pick < 85) shape = SHAPE_NOISE;
        else if (pick < 93) shape = SHAPE_CUT;
        else shape = SHAPE_LONG;
        queue_frame(eff_width(wdat[bb3_pkg::FW_W-1:0]), eff_height(hdat), shape, n);
        rand_items += n;
      end
      drain_wait();
    end

    // One full frame at full rate; the output holds off for a long stretch
    // early in it so that the block backs up its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_frame(13'd24, 13'd8);
    hold_delay = 30;
    queue_frame(24, 8, SHAPE_CLEAN, n);
    drain_wait();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_out_stage.sv
design/box_blur_3x3_rgb.sv
bench/tb_top.sv
